### src/mbm_pkg.sv
// Shared constants and codes for the masked box-mean raster filter.
package mbm_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_HALF_WINDOW_DEF = 3;
  localparam int MAX_WIDTH_DEF       = 1024;
  localparam int SAMPLE_BITS_DEF     = 16;

  // Frame height limit and row position width.
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_BITS   = 10;

  // Configuration port and register widths.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 11;
  localparam int HALF_REG_BITS = 2;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_HALF_WINDOW  = 2'd2
  } cfg_idx_t;

  // Input item operation codes.
  typedef enum logic {
    OP_RASTER = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

endpackage

### src/mbm_in_if.sv
// Input channel carrying one raster cell or flush tick per item.
interface mbm_in_if #(
  parameter int SAMPLE_BITS = mbm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [SAMPLE_BITS-1:0] pixel_value;
  logic                          pixel_valid;

  modport source (output valid, op, pixel_value, pixel_valid, input ready);
  modport sink (input valid, op, pixel_value, pixel_valid, output ready);
endinterface

### src/mbm_out_if.sv
// Result channel carrying one smoothed cell per item.
interface mbm_out_if #(
  parameter int SAMPLE_BITS = mbm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_value;
  logic                          out_valid;
  logic                          frame_end;

  modport source (output valid, out_value, out_valid, frame_end, input ready);
  modport sink (input valid, out_value, out_valid, frame_end, output ready);
endinterface

### src/mbm_cfg_if.sv
// Configuration write channel.
interface mbm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mbm_pkg::CFG_IDX_BITS-1:0]    reg_index;
  logic [mbm_pkg::CFG_DATA_BITS-1:0]   wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

### src/mbm_div_cell.sv
// One restoring-division cell: produces one quotient bit per item passing through.
module mbm_div_cell #(
  parameter int NUM_BITS = 22,
  parameter int DEN_BITS = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                v_i,
  input  logic [DEN_BITS-1:0] rem_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [NUM_BITS-1:0] quo_i,
  input  logic [DEN_BITS-1:0] den_i,
  output logic                v_o,
  output logic [DEN_BITS-1:0] rem_o,
  output logic [NUM_BITS-1:0] num_o,
  output logic [NUM_BITS-1:0] quo_o,
  output logic [DEN_BITS-1:0] den_o
);
  logic [DEN_BITS:0] trial;
  logic [DEN_BITS:0] diff;
  logic              ge;

  // Bring down the next numerator bit and try a subtraction.
  always_comb begin
    trial = {rem_i, num_i[NUM_BITS-1]};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
  end

  // Control: the valid flag moves one cell per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else begin
      v_o <= v_i;
    end
  end

  // Payload handed to the neighbor cell.
  always_ff @(posedge clk) begin
    rem_o <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
    num_o <= {num_i[NUM_BITS-2:0], 1'b0};
    quo_o <= {quo_i[NUM_BITS-2:0], ge};
    den_o <= den_i;
  end
endmodule

### src/masked_box_mean_raster_filter.sv
// Top level of the masked box-mean raster filter: line store, window sweep, divider chain.
//
//  Channel | Dir | Handshake    | Payload
//  in_ch   | in  | valid/ready  | op, pixel_value, pixel_valid
//  out_ch  | out | valid/ready  | out_value, out_valid, frame_end
//  cfg_ch  | in  | valid/ready  | reg_index, wr_data
//
// An item that causes no result leaves the filter in ST_IDLE, ready for the next item. An
// item that causes a result runs ST_SWEEP, with one line-store read per sweep cycle, then
// ST_DRAIN and ST_DIV, then the divider chain and ST_WAIT when the centre cell holds data,
// and ST_DONE. Reset clears the input and output positions and the pending count; the line
// store is not cleared. A stalled result sits in the output register while the next item
// is taken.
module masked_box_mean_raster_filter #(
  parameter int MAX_HALF_WINDOW = mbm_pkg::MAX_HALF_WINDOW_DEF,
  parameter int MAX_WIDTH       = mbm_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS     = mbm_pkg::SAMPLE_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mbm_in_if.sink    in_ch,
  mbm_out_if.source out_ch,
  mbm_cfg_if.sink   cfg_ch
);
  import mbm_pkg::*;

  localparam int LsRows    = 2 * MAX_HALF_WINDOW + 2;
  localparam int SlotBits  = $clog2(LsRows);
  localparam int ColBits   = $clog2(MAX_WIDTH);
  localparam int WBits     = $clog2(MAX_WIDTH + 1);
  localparam int HBits     = $clog2(MAX_HEIGHT + 1);
  localparam int HwBits    = $clog2(MAX_HALF_WINDOW + 1);
  localparam int AddrBits  = $clog2(LsRows * MAX_WIDTH);
  localparam int Depth     = LsRows * MAX_WIDTH;
  localparam int CntBits   = $clog2((2 * MAX_HALF_WINDOW + 1) * (2 * MAX_HALF_WINDOW + 1) + 1);
  localparam int SumBits   = SAMPLE_BITS + CntBits;
  localparam int NumBits   = SAMPLE_BITS + CntBits;
  localparam int DenBits   = CntBits + 1;
  localparam int PendMax   = MAX_HALF_WINDOW * MAX_WIDTH + MAX_HALF_WINDOW + 1;
  localparam int PendBits  = $clog2(PendMax + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SWEEP, ST_DRAIN, ST_DIV, ST_WAIT, ST_DONE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [CFG_DATA_BITS-1:0] frame_width_r, frame_height_r;
  logic [HALF_REG_BITS-1:0] half_window_r;

  // Positions and counters.
  logic [ColBits-1:0]  in_col_r, out_col_r, e_col_r;
  logic [ROW_BITS-1:0] in_row_r, out_row_r, e_row_r;
  logic [SlotBits-1:0] in_slot_r, out_slot_r, e_slot_r;
  logic [PendBits-1:0] pending_r;

  // Sweep state.
  logic signed [HwBits:0]  dr_r, dc_r;
  logic                    rd_use_r, rd_ctr_r;
  logic signed [SumBits-1:0] sum_r;
  logic [CntBits-1:0]      cnt_r;
  logic                    centre_r, neg_r, fend_r;
  logic [SAMPLE_BITS-1:0]  res_r;
  logic                    resv_r;

  // Output register.
  logic                    opend_r, o_valid_r, o_fend_r;
  logic [SAMPLE_BITS-1:0]  o_value_r;
  logic                    o_load;

  // Line store.
  logic [SAMPLE_BITS:0]    mem [Depth];
  logic [SAMPLE_BITS:0]    mem_q_r;
  logic                    mem_we;
  logic [AddrBits-1:0]     wr_addr, rd_addr;

  // Effective configuration.
  logic [WBits-1:0]    w_eff;
  logic [HBits-1:0]    h_eff;
  logic [HwBits-1:0]   hw_eff;
  logic [PendBits-1:0] delay;

  always_comb begin
    if (frame_width_r == '0) w_eff = WBits'(1);
    else if (int'(frame_width_r) > MAX_WIDTH) w_eff = WBits'(MAX_WIDTH);
    else w_eff = WBits'(frame_width_r);
    if (frame_height_r == '0) h_eff = HBits'(1);
    else if (int'(frame_height_r) > MAX_HEIGHT) h_eff = HBits'(MAX_HEIGHT);
    else h_eff = HBits'(frame_height_r);
    if (int'(half_window_r) > MAX_HALF_WINDOW) hw_eff = HwBits'(MAX_HALF_WINDOW);
    else hw_eff = HwBits'(half_window_r);
    delay = PendBits'(int'(hw_eff) * int'(w_eff) + int'(hw_eff));
  end

  // Handshakes.
  logic in_acc, out_acc;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // The finished result moves into the output register once that register is empty or its result is being taken.
  assign o_load = (state_r == ST_DONE) && (!opend_r || out_acc);

  // Input position for a raster cell, with wrap of a stale column or row.
  logic                in_wrap;
  logic [ColBits-1:0]  col0;
  logic [SlotBits-1:0] slot0, slot0_inc;
  logic [ROW_BITS:0]   row0t;
  logic [ROW_BITS-1:0] row0;
  logic [ColBits:0]    col1;
  logic [ROW_BITS:0]   row1t;
  logic [PendBits-1:0] pend_inc;
  logic                do_emit;
  logic [PendBits-1:0] pending_nxt;

  always_comb begin
    in_wrap = int'(in_col_r) >= int'(w_eff);
    col0    = in_wrap ? '0 : in_col_r;
    if (in_wrap) begin
      slot0 = (int'(in_slot_r) == LsRows - 1) ? '0 : in_slot_r + SlotBits'(1);
      row0t = {1'b0, in_row_r} + (ROW_BITS + 1)'(1);
    end else begin
      slot0 = in_slot_r;
      row0t = {1'b0, in_row_r};
    end
    row0      = (int'(row0t) >= int'(h_eff)) ? '0 : row0t[ROW_BITS-1:0];
    slot0_inc = (int'(slot0) == LsRows - 1) ? '0 : slot0 + SlotBits'(1);
    col1      = {1'b0, col0} + (ColBits + 1)'(1);
    row1t     = {1'b0, row0} + (ROW_BITS + 1)'(1);
    pend_inc  = pending_r + PendBits'(1);
    if (in_ch.op == OP_RASTER) begin
      do_emit = pend_inc > delay;
    end else begin
      do_emit = (pending_r != '0) && (in_row_r == '0) && (in_col_r == '0);
    end
    if (in_ch.op == OP_RASTER) begin
      pending_nxt = do_emit ? pending_r : pend_inc;
    end else begin
      pending_nxt = do_emit ? pending_r - PendBits'(1) : pending_r;
    end
    mem_we  = in_acc && (in_ch.op == OP_RASTER);
    wr_addr = AddrBits'(int'(slot0) * MAX_WIDTH + int'(col0));
  end

  // Window sweep address and bounds.
  logic signed [ROW_BITS+1:0] r_s;
  logic signed [ColBits+1:0]  c_s;
  logic signed [SlotBits+1:0] s_s;
  logic [SlotBits-1:0]        rd_slot;
  logic                       in_bounds, last_tap;
  logic signed [HwBits:0]     hw_s;

  always_comb begin
    hw_s = $signed({1'b0, hw_eff});
    r_s  = $signed({2'b00, e_row_r}) + (ROW_BITS + 2)'(dr_r);
    c_s  = $signed({2'b00, e_col_r}) + (ColBits + 2)'(dc_r);
    s_s  = $signed({2'b00, e_slot_r}) + (SlotBits + 2)'(dr_r);
    if (s_s < 0) s_s = s_s + (SlotBits + 2)'(LsRows);
    else if (s_s >= (SlotBits + 2)'(LsRows)) s_s = s_s - (SlotBits + 2)'(LsRows);
    rd_slot   = s_s[SlotBits-1:0];
    in_bounds = (r_s >= 0) && (int'(r_s) < int'(h_eff)) &&
                (c_s >= 0) && (int'(c_s) < int'(w_eff));
    rd_addr   = AddrBits'(int'(rd_slot) * MAX_WIDTH + int'(c_s[ColBits-1:0]));
    last_tap  = (dr_r == hw_s) && (dc_r == hw_s);
  end

  // Line store write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {in_ch.pixel_valid, in_ch.pixel_value};
    end
    mem_q_r <= mem[rd_addr];
  end

  // Divider chain.
  logic                mag_neg;
  logic [SumBits-1:0]  mag;
  logic [NumBits-1:0]  num_in;
  logic [DenBits-1:0]  den_in;
  logic                div_go;
  logic [NumBits:0]    dv;
  logic [DenBits-1:0]  drem [NumBits+1];
  logic [NumBits-1:0]  dnum [NumBits+1];
  logic [NumBits-1:0]  dquo [NumBits+1];
  logic [DenBits-1:0]  dden [NumBits+1];

  always_comb begin
    mag_neg = sum_r[SumBits-1];
    mag     = mag_neg ? SumBits'(-sum_r) : SumBits'(sum_r);
    num_in  = NumBits'({mag[NumBits-2:0], 1'b0}) + NumBits'(cnt_r);
    den_in  = {cnt_r, 1'b0};
    div_go  = (state_r == ST_DIV) && centre_r && (cnt_r != '0);
    dv[0]   = div_go;
    drem[0] = '0;
    dnum[0] = num_in;
    dquo[0] = '0;
    dden[0] = den_in;
  end

  for (genvar g = 0; g < NumBits; g++) begin : g_div
    mbm_div_cell #(
      .NUM_BITS (NumBits),
      .DEN_BITS (DenBits)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (dv[g]),
      .rem_i (drem[g]),
      .num_i (dnum[g]),
      .quo_i (dquo[g]),
      .den_i (dden[g]),
      .v_o   (dv[g+1]),
      .rem_o (drem[g+1]),
      .num_o (dnum[g+1]),
      .quo_o (dquo[g+1]),
      .den_o (dden[g+1])
    );
  end

  logic [SAMPLE_BITS-1:0] q_lo;
  assign q_lo = dquo[NumBits][SAMPLE_BITS-1:0];

  // Control state machine with registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      frame_width_r  <= CFG_DATA_BITS'(1024);
      frame_height_r <= CFG_DATA_BITS'(1024);
      half_window_r  <= HALF_REG_BITS'(1);
      in_col_r       <= '0;
      in_row_r       <= '0;
      in_slot_r      <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      out_slot_r     <= '0;
      pending_r      <= '0;
      rd_use_r       <= 1'b0;
      rd_ctr_r       <= 1'b0;
      opend_r        <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_ch.valid) begin
        unique case (cfg_idx_t'(cfg_ch.reg_index))
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_ch.wr_data;
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_ch.wr_data;
          CFG_HALF_WINDOW:  half_window_r  <= cfg_ch.wr_data[HALF_REG_BITS-1:0];
          default: ;
        endcase
      end

      if (o_load) opend_r <= 1'b1;
      else if (out_acc) opend_r <= 1'b0;

      rd_use_r <= (state_r == ST_SWEEP) && in_bounds;
      rd_ctr_r <= (state_r == ST_SWEEP) && (dr_r == '0) && (dc_r == '0);

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            pending_r <= pending_nxt;
            if (in_ch.op == OP_RASTER) begin
              if (int'(col1) >= int'(w_eff)) begin
                in_col_r  <= '0;
                in_slot_r <= slot0_inc;
                in_row_r  <= (int'(row1t) >= int'(h_eff)) ? '0 : row1t[ROW_BITS-1:0];
              end else begin
                in_col_r  <= col1[ColBits-1:0];
                in_slot_r <= slot0;
                in_row_r  <= row0;
              end
            end
            if (do_emit) begin
              e_row_r  <= out_row_r;
              e_col_r  <= out_col_r;
              e_slot_r <= out_slot_r;
              fend_r   <= (int'(out_row_r) == int'(h_eff) - 1) &&
                          (int'(out_col_r) == int'(w_eff) - 1);
              if (int'(out_col_r) + 1 >= int'(w_eff)) begin
                out_col_r  <= '0;
                out_slot_r <= (int'(out_slot_r) == LsRows - 1) ? '0
                              : out_slot_r + SlotBits'(1);
                out_row_r  <= (int'(out_row_r) + 1 >= int'(h_eff)) ? '0
                              : out_row_r + ROW_BITS'(1);
              end else begin
                out_col_r <= out_col_r + ColBits'(1);
              end
              dr_r     <= -hw_s;
              dc_r     <= -hw_s;
              sum_r    <= '0;
              cnt_r    <= '0;
              centre_r <= 1'b0;
              state_r  <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (dc_r == hw_s) begin
            dc_r <= -hw_s;
            dr_r <= dr_r + (HwBits + 1)'(1);
          end else begin
            dc_r <= dc_r + (HwBits + 1)'(1);
          end
          if (last_tap) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          neg_r <= mag_neg;
          if (div_go) begin
            state_r <= ST_WAIT;
          end else begin
            res_r   <= '0;
            resv_r  <= centre_r;
            state_r <= ST_DONE;
          end
        end
        ST_WAIT: begin
          if (dv[NumBits]) begin
            res_r   <= neg_r ? (~q_lo + SAMPLE_BITS'(1)) : q_lo;
            resv_r  <= 1'b1;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (o_load) begin
            o_value_r <= res_r;
            o_valid_r <= resv_r;
            o_fend_r  <= fend_r;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // Accumulate the tap read in the previous cycle.
      if (rd_use_r && mem_q_r[SAMPLE_BITS]) begin
        sum_r <= sum_r + SumBits'($signed(mem_q_r[SAMPLE_BITS-1:0]));
        cnt_r <= cnt_r + CntBits'(1);
      end
      if (rd_ctr_r) centre_r <= mem_q_r[SAMPLE_BITS];
    end
  end

  // Result channel.
  assign out_ch.valid     = opend_r;
  assign out_ch.out_value = o_value_r;
  assign out_ch.out_valid = o_valid_r;
  assign out_ch.frame_end = o_fend_r;

  // At most one item travels through the divider chain.
  a_one_div: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(dv) <= 1)
    else $error("more than one item in the divider chain");

  // The pending count never exceeds the longest window delay plus one.
  a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pending_r) <= PendMax)
    else $error("pending count out of range");

  // A valid centre cell is always counted in its own window.
  a_centre_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && centre_r |-> cnt_r != '0)
    else $error("valid centre with empty window");

endmodule
